>>> hw/rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer: word formats of the
// command and pixel channels and the classified operation held in the queue.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int COORD_BITS = 10;

	typedef logic [COORD_BITS-1:0] coord_t;

	// action codes of a command word
	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	// command channel word
	typedef struct packed {
		action_t action;
		coord_t  x_start;
		coord_t  y_start;
		coord_t  x_end;
		coord_t  y_end;
	} cmd_t;

	// pixel channel word
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last_pixel;
	} pix_t;

	// stepping directions of a line
	typedef struct packed {
		logic x_major;
		logic major_down;
		logic minor_down;
	} dir_t;

	// classified operation passed from front to back
	typedef struct packed {
		action_t action;
		coord_t  major_start;
		coord_t  minor_start;
		coord_t  minor_delta_abs;
		coord_t  line_length;
		coord_t  rem_init;
		dir_t    dir;
	} op_t;

endpackage

>>> hw/rtl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Classifies command words: a load gets its deltas, major axis, line length,
// direction bits and starting remainder worked out; a step passes as is.
// ----------------------------------------------------------------------------
module dda_front (
	input  dda_pkg::cmd_t cmd,
	output dda_pkg::op_t  op
);
	import dda_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	coord_t adx;
	coord_t ady;
	logic   x_major;
	logic   min_neg;
	coord_t len;

	// signed deltas and their magnitudes
	always_comb begin
		dx  = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
		dy  = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
		adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
	end

	// major axis selection, x wins a tie
	always_comb begin
		x_major = (adx >= ady);
		min_neg = x_major ? dy[COORD_BITS] : dx[COORD_BITS];
		len     = x_major ? adx : ady;

		op.action          = cmd.action;
		op.major_start     = x_major ? cmd.x_start : cmd.y_start;
		op.minor_start     = x_major ? cmd.y_start : cmd.x_start;
		op.minor_delta_abs = x_major ? ady : adx;
		op.line_length     = len;
		op.dir.x_major     = x_major;
		op.dir.major_down  = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
		op.dir.minor_down  = min_neg;
		// negative minor delta starts the remainder at L-1 for floor rounding
		op.rem_init        = (min_neg && (len != '0)) ? len - 1'b1 : '0;
	end

endmodule

>>> hw/rtl/dda_queue.sv
// ----------------------------------------------------------------------------
// dda_queue
// Small first-in first-out queue of classified operations between the front
// and back halves of the rasterizer.
// ----------------------------------------------------------------------------
module dda_queue #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  dda_pkg::op_t wdata,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output dda_pkg::op_t rdata
);
	import dda_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Executes queued operations: a load replaces the line state, a step on a live
// line emits one pixel into the output register and advances the accumulator.
// ----------------------------------------------------------------------------
module dda_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  dda_pkg::op_t  head,
	output logic          pop,
	output logic          pix_valid,
	input  logic          pix_stall,
	output dda_pkg::pix_t pix
);
	import dda_pkg::*;

	coord_t major_pos_q;
	coord_t minor_pos_q;
	coord_t rem_q;
	coord_t minor_delta_abs_q;
	coord_t line_length_q;
	coord_t pixels_left_q;
	dir_t   dir_q;
	logic   active_q;
	logic   out_valid_q;
	pix_t   out_q;

	logic              out_free;
	logic              is_load;
	logic              emit;
	logic [COORD_BITS:0] rem_sum;
	logic              minor_step;

	assign out_free  = !out_valid_q || !pix_stall;
	assign is_load   = (head.action == ACT_LOAD);
	assign pop       = head_valid && (is_load || !active_q || out_free);
	assign emit      = head_valid && !is_load && active_q && out_free;
	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	// remainder accumulator, sum stays below twice the line length
	always_comb begin
		rem_sum    = {1'b0, rem_q} + {1'b0, minor_delta_abs_q};
		minor_step = (rem_sum >= {1'b0, line_length_q});
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_x    <= dir_q.x_major ? major_pos_q : minor_pos_q;
			out_q.pixel_y    <= dir_q.x_major ? minor_pos_q : major_pos_q;
			out_q.last_pixel <= (pixels_left_q == COORD_BITS'(1));
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q       <= '0;
			minor_pos_q       <= '0;
			rem_q             <= '0;
			minor_delta_abs_q <= '0;
			line_length_q     <= '0;
			pixels_left_q     <= '0;
			dir_q             <= '0;
			active_q          <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end

			if (pop && is_load) begin
				major_pos_q       <= head.major_start;
				minor_pos_q       <= head.minor_start;
				rem_q             <= head.rem_init;
				minor_delta_abs_q <= head.minor_delta_abs;
				line_length_q     <= head.line_length;
				pixels_left_q     <= head.line_length;
				dir_q             <= head.dir;
				active_q          <= (head.line_length != '0);
			end else if (emit) begin
				major_pos_q <= dir_q.major_down ? major_pos_q - 1'b1 : major_pos_q + 1'b1;
				if (minor_step) begin
					rem_q       <= COORD_BITS'(rem_sum - {1'b0, line_length_q});
					minor_pos_q <= dir_q.minor_down ? minor_pos_q - 1'b1
					                                : minor_pos_q + 1'b1;
				end else begin
					rem_q <= COORD_BITS'(rem_sum);
				end
				pixels_left_q <= pixels_left_q - 1'b1;
				if (pixels_left_q == COORD_BITS'(1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> hw/rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: load words set up a line, step words each return the
// next pixel of it, with the minor axis kept exact by a remainder accumulator.
//
//   channel   dir   handshake            word
//   cmd       in    cmd_valid/cmd_stall  action, x_start, y_start, x_end, y_end
//   pix       out   pix_valid/pix_stall  pixel_x, pixel_y, last_pixel
//
// One command word is taken per cycle while cmd_stall is low; each step with a
// live line gives its pixel through the queue and the output register, so a
// stream of steps yields one pixel every clock while pix_stall is low. The back
// end retires one queued word per cycle unless a live-line step waits on a
// stalled pixel. cmd_stall rises only when the DEPTH-entry queue is full,
// which happens only while a pixel word is held in the output register.
// Reset clears the queue, the line state and the output valid.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dda_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_stall,
	output dda_pkg::pix_t pix
);
	import dda_pkg::*;

	op_t  front_op;
	op_t  head_op;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign cmd_stall = q_full;

	// classify incoming words
	dda_front u_front (
		.cmd (cmd),
		.op  (front_op)
	);

	// decouple front and back
	dda_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.wdata  (front_op),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (head_op)
	);

	// execute and emit pixels
	dda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head_op),
		.pop        (q_pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix)
	);

endmodule

>>> hw/rtl/dda_checker.sv
// ----------------------------------------------------------------------------
// dda_checker
// Port-level checks of the rasterizer: output hold under stall, queue full
// only behind a stalled pixel, and no pixel without an earlier step word.
// ----------------------------------------------------------------------------
module dda_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input dda_pkg::cmd_t cmd,
	input logic          pix_valid,
	input logic          pix_stall,
	input dda_pkg::pix_t pix
);
	import dda_pkg::*;

	logic [31:0] credit_q;
	logic        step_acc;
	logic        pix_acc;

	assign step_acc = cmd_valid && !cmd_stall && (cmd.action == ACT_STEP);
	assign pix_acc  = pix_valid && !pix_stall;

	// steps taken minus pixels delivered, frozen once saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (credit_q != '1) begin
			if (step_acc && !pix_acc) begin
				credit_q <= credit_q + 1'b1;
			end else if (pix_acc && !step_acc && (credit_q != '0)) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

	// stalled pixel word holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("pixel word changed while stalled");

	// queue fills only behind a stalled pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> pix_valid)
		else $error("command stall without a pending pixel");

	// queue empty out of reset
	a_reset_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !cmd_stall)
		else $error("command stall right after reset");

	// every pixel answers an earlier step word
	a_pix_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |-> credit_q != '0)
		else $error("pixel delivered without a step word");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix)
);

>>> verif/dda_pixel_checker.sv
// ----------------------------------------------------------------------------
// dda_pixel_checker
// Watches the command and pixel channels of the line rasterizer. It tracks
// the line state from every accepted command word, queues the pixel each
// live step should give, and compares each accepted pixel word with the
// oldest queued one. It reports mismatches and counts failures.
// ----------------------------------------------------------------------------
module dda_pixel_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  dda_pkg::cmd_t cmd,
	input  logic          pix_valid,
	input  logic          pix_stall,
	input  dda_pkg::pix_t pix,
	output int            fail_count,
	output int            pending_pixels
);
	import dda_pkg::*;

	// predicted line state
	coord_t      major_pos;
	coord_t      minor_pos;
	logic [10:0] minor_rem;
	coord_t      minor_step;
	coord_t      span;
	logic [10:0] pixels_left;
	dir_t        dir;
	logic        line_live;

	// pixels still owed by the block, oldest first
	pix_t expected_pixels[$];

	always @(posedge clk or negedge arst_n) begin : track
		int   ddx;
		int   ddy;
		int   adx;
		int   ady;
		int   rem_next;
		pix_t want;
		if (!arst_n) begin
			major_pos      = '0;
			minor_pos      = '0;
			minor_rem      = '0;
			minor_step     = '0;
			span           = '0;
			pixels_left    = '0;
			dir            = '0;
			line_live      = 1'b0;
			fail_count     = 0;
			expected_pixels.delete();
			pending_pixels = 0;
		end else begin
			// compare an accepted pixel word with the oldest prediction
			if (pix_valid && !pix_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel word with none expected: x %0d y %0d last %0d",
						pix.pixel_x, pix.pixel_y, pix.last_pixel);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (pix.pixel_x !== want.pixel_x) begin
						$error("pixel_x: expected %0d, actual %0d",
							want.pixel_x, pix.pixel_x);
						fail_count++;
					end
					if (pix.pixel_y !== want.pixel_y) begin
						$error("pixel_y: expected %0d, actual %0d",
							want.pixel_y, pix.pixel_y);
						fail_count++;
					end
					if (pix.last_pixel !== want.last_pixel) begin
						$error("last_pixel: expected %0d, actual %0d",
							want.last_pixel, pix.last_pixel);
						fail_count++;
					end
				end
			end

			// follow an accepted command word
			if (cmd_valid && !cmd_stall) begin
				if (cmd.action == ACT_LOAD) begin
					// new line replaces any in progress
					ddx = int'(cmd.x_end) - int'(cmd.x_start);
					ddy = int'(cmd.y_end) - int'(cmd.y_start);
					adx = (ddx < 0) ? -ddx : ddx;
					ady = (ddy < 0) ? -ddy : ddy;
					if (adx >= ady) begin
						dir.x_major    = 1'b1;
						dir.major_down = ddx < 0;
						dir.minor_down = ddy < 0;
						span           = coord_t'(adx);
						minor_step     = coord_t'(ady);
						major_pos      = cmd.x_start;
						minor_pos      = cmd.y_start;
					end else begin
						dir.x_major    = 1'b0;
						dir.major_down = ddy < 0;
						dir.minor_down = ddx < 0;
						span           = coord_t'(ady);
						minor_step     = coord_t'(adx);
						major_pos      = cmd.y_start;
						minor_pos      = cmd.x_start;
					end
					pixels_left = 11'(span);
					line_live   = span != '0;
					// a falling minor axis rounds down, so the remainder starts high
					if (dir.minor_down && span != '0)
						minor_rem = 11'(span) - 11'd1;
					else
						minor_rem = '0;
				end else if (line_live) begin
					want.pixel_x    = dir.x_major ? major_pos : minor_pos;
					want.pixel_y    = dir.x_major ? minor_pos : major_pos;
					want.last_pixel = pixels_left == 11'd1;
					expected_pixels.push_back(want);

					// advance along the major axis
					if (dir.major_down)
						major_pos = major_pos - 1'b1;
					else
						major_pos = major_pos + 1'b1;

					// exact minor stepping by remainder
					rem_next = int'(minor_rem) + int'(minor_step);
					if (rem_next >= int'(span)) begin
						rem_next = rem_next - int'(span);
						if (dir.minor_down)
							minor_pos = minor_pos - 1'b1;
						else
							minor_pos = minor_pos + 1'b1;
					end
					minor_rem = 11'(rem_next);

					pixels_left = pixels_left - 11'd1;
					if (pixels_left == '0)
						line_live = 1'b0;
				end
			end
			pending_pixels = expected_pixels.size();
		end
	end

endmodule

>>> verif/dda_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// Regression for the line rasterizer. Sends directed lines in every
// direction and at the coordinate extremes, then random lines with random
// step counts, under bursty input and a patterned output stall with one
// long hold-off. The pixel checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

	import dda_pkg::*;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;

	int fail_count;
	int pending_pixels;

	// sender bookkeeping
	int burst_left;
	int items_sent;
	int line_left;
	bit hold_go;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	dda_line_rasterizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	dda_pixel_checker pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.cmd            (cmd),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pix            (pix),
		.fail_count     (fail_count),
		.pending_pixels (pending_pixels)
	);

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	function automatic cmd_t load_word(input int xs, input int ys, input int xe, input int ye);
		cmd_t w;
		w.action  = ACT_LOAD;
		w.x_start = coord_t'(xs);
		w.y_start = coord_t'(ys);
		w.x_end   = coord_t'(xe);
		w.y_end   = coord_t'(ye);
		return w;
	endfunction

	// step word with junk in the unused coordinate fields
	function automatic cmd_t step_word();
		cmd_t w;
		w.action  = ACT_STEP;
		w.x_start = coord_t'($urandom);
		w.y_start = coord_t'($urandom);
		w.x_end   = coord_t'($urandom);
		w.y_end   = coord_t'($urandom);
		return w;
	endfunction

	// offer one word in bursts with random gaps, return on acceptance
	task automatic send_word(input cmd_t w);
		int gap;
		int adx;
		int ady;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		burst_left--;
		// count loads and steps that still have a pixel to give
		if (w.action == ACT_LOAD) begin
			adx = int'(w.x_end) - int'(w.x_start);
			ady = int'(w.y_end) - int'(w.y_start);
			adx = (adx < 0) ? -adx : adx;
			ady = (ady < 0) ? -ady : ady;
			line_left = (adx >= ady) ? adx : ady;
			items_sent++;
		end else if (line_left > 0) begin
			line_left--;
			items_sent++;
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic draw_line(input cmd_t ld, input int steps);
		send_word(ld);
		repeat (steps) send_word(step_word());
	endtask

	// stop offering and wait until every owed pixel has come out
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_pixels != 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	// receiver stall pattern with one long hold-off
	initial begin : pix_sink
		int mode;
		int mode_left;
		int hold_left;
		bit held;
		pix_stall = 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pix_stall <= 1'b1;
			end else if (hold_go && !held) begin
				held      = 1'b1;
				hold_left = 300;
				pix_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					0: pix_stall <= 1'b0;
					1: pix_stall <= ($urandom_range(0, 3) == 0);
					2: pix_stall <= ($urandom_range(0, 1) == 0);
					default: pix_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int sel;
		int xs;
		int ys;
		int xe;
		int ye;
		int len;
		int steps;
		int off;
		bit paused;
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd        = '0;
		hold_go    = 1'b0;
		burst_left = 0;
		items_sent = 0;
		line_left  = 0;
		paused     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step with no line after reset
		send_word(step_word());
		// zero-length line, its step gives nothing
		draw_line(load_word(7, 7, 7, 7), 1);
		// tie goes to x, falling minor, corner extremes
		draw_line(load_word(0, 1023, 1023, 0), 2);
		// replace a line in progress, major axis stepping down
		draw_line(load_word(1023, 0, 0, 1023), 1);
		// y major stepping down, rising minor, one step past the end
		draw_line(load_word(10, 20, 11, 16), 5);
		// x major stepping down, rising minor
		draw_line(load_word(100, 100, 97, 102), 3);
		// y major stepping up, falling minor
		draw_line(load_word(5, 5, 3, 9), 4);

		// random lines
		while (items_sent < 1500) begin
			if (!hold_go && items_sent >= 500) begin
				// long line while the receiver holds off, fills the block
				hold_go = 1'b1;
				draw_line(load_word(0, 0, 200, 37), 150);
			end
			if (!paused && items_sent >= 1000) begin
				paused = 1'b1;
				wait_drained();
			end
			sel = $urandom_range(0, 19);
			xs  = $urandom_range(0, 1023);
			ys  = $urandom_range(0, 1023);
			if (sel == 0) begin
				xe = $urandom_range(0, 1023);
				ye = $urandom_range(0, 1023);
			end else if (sel == 1) begin
				xe = xs;
				ye = ys;
			end else if (sel == 2) begin
				off = $urandom_range(0, 60) - 30;
				if ($urandom_range(0, 1) == 0) begin
					xe = clamp_coord(xs + off);
					ye = ys;
				end else begin
					xe = xs;
					ye = clamp_coord(ys + off);
				end
			end else if (sel == 3) begin
				off = $urandom_range(1, 30);
				xe  = clamp_coord(($urandom_range(0, 1) == 0) ? xs + off : xs - off);
				ye  = clamp_coord(($urandom_range(0, 1) == 0) ? ys + off : ys - off);
			end else if (sel == 4) begin
				// lines starting at the edges of the range
				xs = $urandom_range(0, 1) * 1023;
				ys = $urandom_range(0, 1) * 1023;
				xe = clamp_coord(xs + $urandom_range(0, 40) - 20);
				ye = clamp_coord(ys + $urandom_range(0, 40) - 20);
			end else begin
				xe = clamp_coord(xs + $urandom_range(0, 48) - 24);
				ye = clamp_coord(ys + $urandom_range(0, 48) - 24);
			end
			len = (xe > xs) ? xe - xs : xs - xe;
			if (((ye > ys) ? ye - ys : ys - ye) > len)
				len = (ye > ys) ? ye - ys : ys - ye;
			case ($urandom_range(0, 9))
				0: steps = $urandom_range(0, len);
				1: steps = len + $urandom_range(1, 3);
				default: steps = len;
			endcase
			draw_line(load_word(xs, ys, xe, ye), steps);
		end

		// drain and look for stray pixel words
		wait_drained();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending_pixels == 0)
			$display("dda_line_rasterizer regression: pass");
		else
			$display("dda_line_rasterizer regression: fail");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#2000000;
		$display("dda_line_rasterizer regression: fail");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_front.sv
hw/rtl/dda_queue.sv
hw/rtl/dda_back.sv
hw/rtl/dda_line_rasterizer.sv
hw/rtl/dda_checker.sv
verif/dda_pixel_checker.sv
verif/dda_line_rasterizer_tb.sv
